// ===== design/ipv4p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4p_pkg: shared types and constants of the dotted IPv4 text parser
// Holds the parse phase and radix codes, the character constants and the
// structs that travel between the parser's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4p_pkg;

   // Parse phase of the string that is currently being read.
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_ZERO   = 3'd1,
      PH_DIGITS = 3'd2,
      PH_ACCEPT = 3'd3,
      PH_REJECT = 3'd4
   } phase_type;

   // Number base of the current part.
   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   // Largest value of the last part for two, three and four parts.
   localparam logic [31:0] LIMIT_24 = 32'h00FF_FFFF;
   localparam logic [31:0] LIMIT_16 = 32'h0000_FFFF;
   localparam logic [31:0] LIMIT_8  = 32'h0000_00FF;

   // Number of dot-separated parts kept before the last one.
   localparam int unsigned EARLIER_PARTS = 3;

   // Classification of one character.
   typedef struct packed {
      logic       is_digit;
      logic       is_zero;
      logic       is_hex_letter;
      logic       is_x;
      logic       is_dot;
      logic       is_nul;
      logic       is_space;
      logic [3:0] value;
   } char_class_type;

   // Outcome of one parse step.
   typedef struct packed {
      logic        last;
      logic        valid_res;
      logic [31:0] address;
   } step_out_type;

endpackage

`default_nettype wire

// ===== design/ipv4p_req_if.sv =====
// ----------------------------------------------------------------------------
// ipv4p_req_if: character channel of the dotted IPv4 text parser
// One beat carries one character of the address string.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

// ===== design/ipv4p_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ipv4p_rsp_if: result channel of the dotted IPv4 text parser
// One beat carries the verdict and the address of one finished string.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4p_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [31:0] address;

   modport source (output valid, output valid_res, output address, input ready);
   modport sink   (input valid, input valid_res, input address, output ready);
endinterface

`default_nettype wire

// ===== design/ipv4p_char_class.sv =====
// ----------------------------------------------------------------------------
// ipv4p_char_class: character classifier
// Flags digits, hex letters, the hex prefix letter, dot, NUL and whitespace,
// and gives the nibble value of a digit or hex letter.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4p_char_class (
   input  logic [7:0]                ch,
   output ipv4p_pkg::char_class_type cls
);
   import ipv4p_pkg::*;

   logic is_lower_hex;
   logic is_upper_hex;

   always_comb begin
      is_lower_hex      = (ch >= CH_LO_A) && (ch <= CH_LO_F);
      is_upper_hex      = (ch >= CH_UP_A) && (ch <= CH_UP_F);
      cls.is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
      cls.is_zero       = (ch == CH_ZERO);
      cls.is_hex_letter = is_lower_hex || is_upper_hex;
      cls.is_x          = (ch == CH_LO_X) || (ch == CH_UP_X);
      cls.is_dot        = (ch == CH_DOT);
      cls.is_nul        = (ch == CH_NUL);
      cls.is_space      = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
      // Letters a-f and A-F share their low nibble 1..6, which maps to 10..15.
      if (cls.is_digit) begin
         cls.value = ch[3:0];
      end else begin
         cls.value = ch[3:0] + 4'd9;
      end
   end

endmodule

`default_nettype wire

// ===== design/ipv4p_core.sv =====
// ----------------------------------------------------------------------------
// ipv4p_core: parse state and single-character step
// Holds the phase, the running part value, the radix and the earlier parts,
// and advances them by one character whenever a step fires.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4p_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_fire,
   input  logic [7:0]              step_ch,
   output ipv4p_pkg::step_out_type step_out
);
   import ipv4p_pkg::*;

   char_class_type cls;

   phase_type   phase_ff, phase_in;
   phase_type   eff_phase, step_phase;
   radix_type   radix_ff, radix_in, eff_radix;
   logic [31:0] accum_ff, accum_in;
   logic [1:0]  part_count_ff, part_count_in;
   logic [7:0]  part_byte_ff [EARLIER_PARTS];
   logic        part_wide_ff [EARLIER_PARTS];
   logic        part_we;

   logic        take_digit;
   logic [31:0] accum_next;
   logic [31:0] assembled;
   logic        assemble_ok;
   logic [31:0] result_value;

   ipv4p_char_class u_class (
      .ch  (step_ch),
      .cls (cls)
   );

   // A character after a leading zero that is not x/X starts an octal part
   // and is then handled as a digit-phase character.
   always_comb begin
      eff_phase = phase_ff;
      eff_radix = radix_ff;
      if ((phase_ff == PH_ZERO) && !cls.is_x) begin
         eff_phase = PH_DIGITS;
         eff_radix = RX_OCT;
      end
   end

   assign take_digit = cls.is_digit || ((eff_radix == RX_HEX) && cls.is_hex_letter);

   always_comb begin
      unique case (eff_radix)
         RX_HEX:  accum_next = {accum_ff[27:0], cls.value};
         RX_OCT:  accum_next = {accum_ff[28:0], 3'b000} + {28'd0, cls.value};
         default: accum_next = {accum_ff[28:0], 3'b000} + {accum_ff[30:0], 1'b0}
                               + {28'd0, cls.value};
      endcase
   end

   // Combine the last part with the earlier ones and check field widths.
   always_comb begin
      unique case (part_count_ff)
         2'd0: begin
            assemble_ok = 1'b1;
            assembled   = accum_ff;
         end
         2'd1: begin
            assemble_ok = (accum_ff <= LIMIT_24) && !part_wide_ff[0];
            assembled   = {part_byte_ff[0], accum_ff[23:0]};
         end
         2'd2: begin
            assemble_ok = (accum_ff <= LIMIT_16) && !part_wide_ff[0] && !part_wide_ff[1];
            assembled   = {part_byte_ff[0], part_byte_ff[1], accum_ff[15:0]};
         end
         default: begin
            assemble_ok = (accum_ff <= LIMIT_8) && !part_wide_ff[0] && !part_wide_ff[1]
                          && !part_wide_ff[2];
            assembled   = {part_byte_ff[0], part_byte_ff[1], part_byte_ff[2],
                           accum_ff[7:0]};
         end
      endcase
   end

   // Next phase.
   always_comb begin
      unique case (eff_phase)
         PH_START: begin
            if (cls.is_digit) begin
               step_phase = cls.is_zero ? PH_ZERO : PH_DIGITS;
            end else begin
               step_phase = PH_REJECT;
            end
         end
         PH_ZERO:  step_phase = PH_DIGITS;
         PH_DIGITS: begin
            priority if (take_digit) begin
               step_phase = PH_DIGITS;
            end else if (cls.is_dot) begin
               step_phase = (part_count_ff == 2'd3) ? PH_REJECT : PH_START;
            end else if (cls.is_nul || cls.is_space) begin
               step_phase = assemble_ok ? PH_ACCEPT : PH_REJECT;
            end else begin
               step_phase = PH_REJECT;
            end
         end
         PH_ACCEPT: step_phase = PH_ACCEPT;
         default:   step_phase = PH_REJECT;
      endcase
      if (!step_fire) begin
         phase_in = phase_ff;
      end else if (cls.is_nul) begin
         phase_in = PH_START;
      end else begin
         phase_in = step_phase;
      end
   end

   // Datapath outputs of the step.
   always_comb begin
      accum_in      = accum_ff;
      radix_in      = radix_ff;
      part_count_in = part_count_ff;
      part_we       = 1'b0;
      if (step_fire) begin
         if (cls.is_nul) begin
            accum_in      = '0;
            radix_in      = RX_DEC;
            part_count_in = '0;
         end else begin
            unique case (eff_phase)
               PH_START: begin
                  if (cls.is_digit) begin
                     accum_in = {28'd0, cls.value};
                     radix_in = RX_DEC;
                  end
               end
               PH_ZERO: radix_in = RX_HEX;
               PH_DIGITS: begin
                  radix_in = eff_radix;
                  priority if (take_digit) begin
                     accum_in = accum_next;
                  end else if (cls.is_dot) begin
                     if (part_count_ff != 2'd3) begin
                        part_we       = 1'b1;
                        part_count_in = part_count_ff + 2'd1;
                        accum_in      = '0;
                        radix_in      = RX_DEC;
                     end
                  end else if (cls.is_space && assemble_ok) begin
                     accum_in = assembled;
                  end else begin
                     accum_in = accum_ff;
                  end
               end
               default: accum_in = accum_ff;
            endcase
         end
      end
   end

   assign result_value       = (eff_phase == PH_DIGITS) ? assembled : accum_ff;
   assign step_out.last      = cls.is_nul;
   assign step_out.valid_res = (step_phase == PH_ACCEPT);
   assign step_out.address   = (step_phase == PH_ACCEPT) ? result_value : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         radix_ff      <= RX_DEC;
         accum_ff      <= '0;
         part_count_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         accum_ff      <= accum_in;
         part_count_ff <= part_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (part_we) begin
         part_byte_ff[part_count_ff] <= accum_ff[7:0];
         part_wide_ff[part_count_ff] <= |accum_ff[31:8];
      end
   end

   // A string-ending step leaves the parser ready for a fresh string.
   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && cls.is_nul |=> phase_ff == PH_START && part_count_ff == 2'd0
                                  && accum_ff == '0)
      else $error("parser did not restart after end of string");

   // Right after a leading zero the running value is zero.
   a_zero_accum: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ZERO |-> accum_ff == '0)
      else $error("nonzero value after leading zero");

   // A fourth dot rejects the string.
   a_fourth_dot: assert property (@(posedge clock) disable iff (reset)
      step_fire && cls.is_dot && phase_ff == PH_DIGITS && part_count_ff == 2'd3
      |=> phase_ff == PH_REJECT)
      else $error("fourth dot not rejected");

endmodule

`default_nettype wire

// ===== design/dotted_ipv4_text_parser.sv =====
// ----------------------------------------------------------------------------
// dotted_ipv4_text_parser: streaming parser for dotted IPv4 address text
// Reads an address string one character per beat on req_chan and returns one
// result beat on rsp_chan for every NUL character that ends a string.
//
// The string may use one to four parts (a, a.b, a.b.c, a.b.c.d), each part
// decimal, octal after a leading 0 or hexadecimal after 0x/0X. A string may
// end in whitespace, after which all characters up to the NUL are ignored.
// The result beat carries valid_res and the address in host order with the
// first part in bits 31..24; the address is zero for a malformed string.
//
// A character beat is taken into an input register, stepped through the
// parse state from that register and, if it is a NUL, lands in the output
// register. One character beat is taken in every cycle, but for the stall
// below. While a result waits in the output register, characters that
// give no result keep flowing; only a NUL that meets a full, stalled
// output register waits in the input register, and ready drops until the
// receiver takes the waiting result.
// Synchronous reset empties both registers and puts the parser at the
// start of a fresh string.
// ----------------------------------------------------------------------------
`default_nettype none

module dotted_ipv4_text_parser (
   input  logic        clock,
   input  logic        reset,
   ipv4p_req_if.sink   req_chan,
   ipv4p_rsp_if.source rsp_chan
);
   import ipv4p_pkg::*;

   // Input register: one character beat waiting for its parse step.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff, in_ch_in;

   // Output register: one result waiting for the receiver.
   logic        out_valid_ff, out_valid_in;
   logic        out_valid_res_ff, out_valid_res_in;
   logic [31:0] out_address_ff, out_address_in;

   step_out_type step_out;
   logic         out_free;
   logic         step_fire;
   logic         req_take;

   ipv4p_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .step_ch   (in_ch_ff),
      .step_out  (step_out)
   );

   // The output register is free when it is empty or emptied this cycle.
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   // A held character steps unless it ends a string and has nowhere to go.
   assign step_fire = in_valid_ff && (!step_out.last || out_free);
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_take  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_chan.ch;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in     = out_valid_ff;
      out_valid_res_in = out_valid_res_ff;
      out_address_in   = out_address_ff;
      if (step_fire && step_out.last) begin
         out_valid_in     = 1'b1;
         out_valid_res_in = step_out.valid_res;
         out_address_in   = step_out.address;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_ch_ff         <= in_ch_in;
      out_valid_res_ff <= out_valid_res_in;
      out_address_ff   <= out_address_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.valid_res = out_valid_res_ff;
   assign rsp_chan.address   = out_address_ff;

   // A rejected string always reports a zero address.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_valid_res_ff |-> out_address_ff == '0)
      else $error("rejected string with nonzero address");

   // A held character that cannot step stays in the input register.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_fire |=> in_valid_ff && $stable(in_ch_ff))
      else $error("held character lost");

   // A stalled result is never overwritten by a new string's result.
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !(step_fire && step_out.last))
      else $error("stalled result overwritten");

endmodule

`default_nettype wire
